// ===== design/ptt_pkg.sv =====
// Package for the periodic timer table: sizes, status codes and the
// memory write request type. No dependencies.
package ptt_pkg;

    localparam int MAX_RULES     = 24;
    localparam int IDX_W         = $clog2(MAX_RULES);
    localparam int CNT_W         = $clog2(MAX_RULES + 1);
    localparam int SEC_W         = 31;
    localparam int TIME_W        = 64;
    localparam int MS_PER_SECOND = 1000;
    localparam int PMS_W         = SEC_W + $clog2(MS_PER_SECOND);

    typedef enum logic [1:0] {
        ST_ADDED = 2'd0,
        ST_FULL  = 2'd1,
        ST_DUE   = 2'd2,
        ST_DONE  = 2'd3
    } status_t;

    typedef struct packed {
        logic              deadline_en;
        logic              period_en;
        logic [IDX_W-1:0]  addr;
        logic [TIME_W-1:0] deadline;
        logic [PMS_W-1:0]  period_ms;
    } mem_wr_t;

endpackage

// ===== design/ptt_if.sv =====
// Item channels of the periodic timer table: request and response.
// Depends on ptt_pkg.
interface ptt_req_if
    import ptt_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              action;
    logic [SEC_W-1:0]  period_seconds;
    logic [TIME_W-1:0] now_ms;
    logic [4:0]        max_due;

    modport source (output valid, action, period_seconds, now_ms, max_due, input ready);
    modport sink   (input valid, action, period_seconds, now_ms, max_due, output ready);
endinterface

interface ptt_rsp_if
    import ptt_pkg::*;
();
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [4:0] rule_index;
    logic [4:0] due_count;
    logic [4:0] rule_count;
    logic       last;

    modport source (output valid, status, rule_index, due_count, rule_count, last,
                    input ready);
    modport sink   (input valid, status, rule_index, due_count, rule_count, last,
                    output ready);
endinterface

// ===== design/ptt_mem.sv =====
// Rule memory: deadline and period (in ms) per rule, one write port,
// one read port with registered read data. Depends on ptt_pkg.
module ptt_mem
    import ptt_pkg::*;
(
    input  logic              clk,
    input  mem_wr_t           wr,
    input  logic              rd_en,
    input  logic [IDX_W-1:0]  rd_addr,
    output logic [TIME_W-1:0] rd_deadline,
    output logic [PMS_W-1:0]  rd_period_ms
);

    logic [TIME_W-1:0] deadline_mem [MAX_RULES];
    logic [PMS_W-1:0]  period_mem   [MAX_RULES];
    logic [TIME_W-1:0] rd_deadline_reg;
    logic [PMS_W-1:0]  rd_period_reg;

    always_ff @(posedge clk)
    begin
        if (wr.deadline_en)
        begin
            deadline_mem[wr.addr] <= wr.deadline;
        end
        if (wr.period_en)
        begin
            period_mem[wr.addr] <= wr.period_ms;
        end
        if (rd_en)
        begin
            rd_deadline_reg <= deadline_mem[rd_addr];
            rd_period_reg   <= period_mem[rd_addr];
        end
    end

    assign rd_deadline  = rd_deadline_reg;
    assign rd_period_ms = rd_period_reg;

endmodule

// ===== design/ptt_ctrl.sv =====
// Sequencer of the periodic timer table: add, scan and result register.
// Depends on ptt_pkg and the channel interfaces.
module ptt_ctrl
    import ptt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    ptt_req_if.sink           req,
    ptt_rsp_if.source         rsp,
    output mem_wr_t           wr,
    output logic              rd_en,
    output logic [IDX_W-1:0]  rd_addr,
    input  logic [TIME_W-1:0] rd_deadline,
    input  logic [PMS_W-1:0]  rd_period_ms
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_SCAN_RD,
        S_SCAN,
        S_DONE
    } state_t;

    state_t            state_reg;
    logic [TIME_W-1:0] now_reg;
    logic [PMS_W-1:0]  mul_reg;
    logic [4:0]        cap_reg;
    logic [CNT_W-1:0]  cur_reg;
    logic [CNT_W-1:0]  found_reg;
    logic [CNT_W-1:0]  used_reg;

    logic              out_valid_reg;
    status_t           out_status_reg;
    logic [CNT_W-1:0]  out_index_reg;
    logic [CNT_W-1:0]  out_due_reg;
    logic [CNT_W-1:0]  out_count_reg;
    logic              out_last_reg;

    logic              slot_free;
    logic              full;
    logic              active;
    logic              due;
    logic              out_load;
    logic [CNT_W-1:0]  cur_next;
    logic [TIME_W-1:0] add_deadline;
    logic [TIME_W-1:0] rearm_deadline;

    assign slot_free      = !out_valid_reg || rsp.ready;
    assign full           = (used_reg >= CNT_W'(MAX_RULES));
    assign active         = (cur_reg < used_reg) && (found_reg < CNT_W'(cap_reg));
    assign due            = (now_reg >= rd_deadline);
    assign cur_next       = cur_reg + CNT_W'(1);
    assign add_deadline   = now_reg + TIME_W'(mul_reg);
    assign rearm_deadline = now_reg + TIME_W'(rd_period_ms);
    assign out_load       = slot_free && ((state_reg == S_ADD) || (state_reg == S_DONE) ||
                                          ((state_reg == S_SCAN) && active && due));

    assign req.ready = (state_reg == S_IDLE);

    always_comb
    begin
        wr          = '0;
        wr.addr     = cur_reg[IDX_W-1:0];
        wr.deadline = rearm_deadline;
        wr.period_ms = mul_reg;
        rd_en       = 1'b0;
        rd_addr     = cur_next[IDX_W-1:0];
        unique case (state_reg)
            S_ADD:
            begin
                wr.addr     = used_reg[IDX_W-1:0];
                wr.deadline = add_deadline;
                if (slot_free && !full)
                begin
                    wr.deadline_en = 1'b1;
                    wr.period_en   = 1'b1;
                end
            end
            S_SCAN_RD:
            begin
                rd_addr = '0;
                rd_en   = (used_reg != '0);
            end
            S_SCAN:
            begin
                if (active && (!due || slot_free))
                begin
                    rd_en          = (cur_next < used_reg);
                    wr.deadline_en = due;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            used_reg       <= '0;
            cur_reg        <= '0;
            found_reg      <= '0;
            out_valid_reg  <= 1'b0;
            now_reg        <= '0;
            mul_reg        <= '0;
            cap_reg        <= '0;
            out_status_reg <= ST_ADDED;
            out_index_reg  <= '0;
            out_due_reg    <= '0;
            out_count_reg  <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        now_reg   <= req.now_ms;
                        cap_reg   <= req.max_due;
                        mul_reg   <= PMS_W'(req.period_seconds) * PMS_W'(MS_PER_SECOND);
                        cur_reg   <= '0;
                        found_reg <= '0;
                        state_reg <= req.action ? S_SCAN_RD : S_ADD;
                    end
                end
                S_ADD:
                begin
                    if (slot_free)
                    begin
                        out_due_reg   <= '0;
                        out_last_reg  <= 1'b1;
                        if (full)
                        begin
                            out_status_reg <= ST_FULL;
                            out_index_reg  <= '0;
                            out_count_reg  <= used_reg;
                        end
                        else
                        begin
                            out_status_reg <= ST_ADDED;
                            out_index_reg  <= used_reg;
                            out_count_reg  <= used_reg + CNT_W'(1);
                            used_reg       <= used_reg + CNT_W'(1);
                        end
                        state_reg <= S_IDLE;
                    end
                end
                S_SCAN_RD:
                begin
                    state_reg <= S_SCAN;
                end
                S_SCAN:
                begin
                    if (!active)
                    begin
                        state_reg <= S_DONE;
                    end
                    else if (!due)
                    begin
                        cur_reg <= cur_next;
                    end
                    else if (slot_free)
                    begin
                        out_status_reg <= ST_DUE;
                        out_index_reg  <= cur_reg;
                        out_due_reg    <= '0;
                        out_count_reg  <= used_reg;
                        out_last_reg   <= 1'b0;
                        found_reg      <= found_reg + CNT_W'(1);
                        cur_reg        <= cur_next;
                    end
                end
                S_DONE:
                begin
                    if (slot_free)
                    begin
                        out_status_reg <= ST_DONE;
                        out_index_reg  <= '0;
                        out_due_reg    <= found_reg;
                        out_count_reg  <= used_reg;
                        out_last_reg   <= 1'b1;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.rule_index = 5'(out_index_reg);
    assign rsp.due_count  = 5'(out_due_reg);
    assign rsp.rule_count = 5'(out_count_reg);
    assign rsp.last       = out_last_reg;

endmodule

// ===== design/periodic_timer_table.sv =====
// Periodic timer table top level: sequencer plus rule memory.
// Depends on ptt_pkg, ptt_req_if/ptt_rsp_if, ptt_ctrl and ptt_mem.
//
// Usage: one request item in on req, one or more response items out on rsp.
// An add item (action 0) returns one item: rule added with its index, or
// table full. A check item (action 1) returns one due item per fired rule,
// in index order, up to max_due, then a done item carrying the count; the
// final item of every request has last set.
// A check reads the rule memory one entry per cycle, while no due rule
// waits on a busy response register, over the used rules until max_due
// rules have fired.
// One request is in work at a time; req.ready is high only when idle, and
// the next request can be taken while the last response still waits.
// Reset clears the rule count and the response register; memory contents
// are left as they are, since only entries below the rule count are read.
// When rsp.ready is low the response register holds its item and the scan
// pauses on the next due entry until the register frees.
module periodic_timer_table
    import ptt_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    ptt_req_if.sink   req,
    ptt_rsp_if.source rsp
);

    mem_wr_t           wr;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic [TIME_W-1:0] rd_deadline;
    logic [PMS_W-1:0]  rd_period_ms;

    ptt_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req),
        .rsp          (rsp),
        .wr           (wr),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .rd_deadline  (rd_deadline),
        .rd_period_ms (rd_period_ms)
    );

    ptt_mem u_mem (
        .clk          (clk),
        .wr           (wr),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .rd_deadline  (rd_deadline),
        .rd_period_ms (rd_period_ms)
    );

endmodule
